>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the key color overlay RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication, checked outside reset.
`define KC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

>>> hw/rtl/kcogd_pkg.sv
// Types, constants, sRGB table and arithmetic helpers for the key color overlay block.
package kcogd_pkg;

   // Field widths
   localparam int CHAN_W   = 8;
   localparam int LIN_W    = 16;
   localparam int SUM_W    = 18;
   localparam int RGB_LANES = 3;
   localparam int TABLE_DEPTH = 1 << CHAN_W;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_LEVEL      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MONO_MODE      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERLAY_ENABLE = 2'd2;

   // Dim level codes
   localparam logic [1:0] DIM_FULL = 2'd0;
   localparam logic [1:0] DIM_OFF  = 2'd3;

   // Divide by 255: x * RECIP >> SHIFT is exact for x below 66052
   localparam int DIV255_SHIFT  = 24;
   localparam int DIV255_PROD_W = 33;
   localparam logic [16:0] DIV255_RECIP = 17'd65794;
   localparam logic [LIN_W-1:0] BLEND_ROUND = 16'd127;

   // Divide by 3: x * RECIP >> SHIFT is exact for any SUM_W-bit x
   localparam int DIV3_SHIFT  = 19;
   localparam int DIV3_PROD_W = SUM_W + DIV3_SHIFT;
   localparam logic [DIV3_SHIFT-1:0] DIV3_RECIP = 19'd174763;

   // Table generation constants
   localparam logic [63:0] SrgbDen   = 64'd269025;
   localparam logic [63:0] SrgbDenSq = 64'd72374450625;
   localparam logic [63:0] LowDen    = 64'd658920;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [LIN_W-1:0]  lin_type;

   typedef struct packed {
      logic [1:0] dim_level;
      logic       mono_mode;
      logic       overlay_enable;
   } cfg_type;

   // sRGB code to Q0.16 linear light; evaluated at elaboration
   function automatic logic [TABLE_DEPTH-1:0][LIN_W-1:0] build_lin_table();
      logic [TABLE_DEPTH-1:0][LIN_W-1:0] tab;
      logic [63:0]  n;
      logic [63:0]  nsq;
      logic [63:0]  lo;
      logic [63:0]  hi;
      logic [63:0]  mid;
      logic [63:0]  q;
      logic [63:0]  ent;
      logic [127:0] lhs;
      logic [127:0] rhs;
      for (int c = 0; c < TABLE_DEPTH; c++) begin
         if (c <= 10) begin
            // linear segment, rounded
            ent = (64'(c) * 64'd13107000 + 64'd329460) / LowDen;
         end else begin
            n   = 64'(c) * 64'd1000 + 64'd14025;
            nsq = n * n;
            lo  = 64'd0;
            hi  = 64'd65536;
            // largest R with R^5 * D^2 <= n^2 * 2^80
            for (int it = 0; it < 17; it++) begin
               if (lo < hi) begin
                  mid = (lo + hi + 64'd1) >> 1;
                  lhs = 128'(mid) * 128'(mid) * 128'(mid) * 128'(mid) * 128'(mid)
                        * 128'(SrgbDenSq);
                  rhs = 128'(nsq) << 80;
                  if (lhs <= rhs) begin
                     lo = mid;
                  end else begin
                     hi = mid - 64'd1;
                  end
               end
            end
            q   = (nsq << 26) / SrgbDenSq;
            ent = (q * lo * 64'd65535 + (64'd1 << 41)) >> 42;
         end
         tab[c] = ent[LIN_W-1:0];
      end
      return tab;
   endfunction

   localparam logic [TABLE_DEPTH-1:0][LIN_W-1:0] LIN_TABLE = build_lin_table();

   // One bit of the inverse search: keep the bit if its entry is not above lin
   function automatic chan_type search_step(input lin_type lin, input chan_type lo,
                                            input int bitpos);
      chan_type cand;
      chan_type res;
      cand = lo | (chan_type'(1) << bitpos);
      res  = lo;
      if (LIN_TABLE[cand] <= lin) begin
         res = cand;
      end
      return res;
   endfunction

   // Nearest code: step up when the next entry is strictly closer
   function automatic chan_type round_code(input lin_type lin, input chan_type lo);
      lin_type  t0;
      lin_type  t1;
      chan_type res;
      t0  = LIN_TABLE[lo];
      t1  = LIN_TABLE[chan_type'(lo + chan_type'(1))];
      res = lo;
      if (lo != '1 && (lin - t0) > (t1 - lin)) begin
         res = chan_type'(lo + chan_type'(1));
      end
      return res;
   endfunction

   // Exact floor(x / 3) by reciprocal multiply
   function automatic lin_type div3(input logic [SUM_W-1:0] x);
      logic [DIV3_PROD_W-1:0] prod;
      prod = DIV3_PROD_W'(x) * DIV3_PROD_W'(DIV3_RECIP);
      return prod[DIV3_SHIFT +: LIN_W];
   endfunction

endpackage

>>> hw/rtl/kcogd_if.sv
// Channel interfaces: key/overlay request, color response and register write.
interface kcogd_req_if;
   logic                 valid;
   logic                 ready;
   kcogd_pkg::chan_type  base_red;
   kcogd_pkg::chan_type  base_green;
   kcogd_pkg::chan_type  base_blue;
   kcogd_pkg::chan_type  over_red;
   kcogd_pkg::chan_type  over_green;
   kcogd_pkg::chan_type  over_blue;
   kcogd_pkg::chan_type  over_alpha;

   modport source (output valid, base_red, base_green, base_blue,
                   over_red, over_green, over_blue, over_alpha, input ready);
   modport sink   (input valid, base_red, base_green, base_blue,
                   over_red, over_green, over_blue, over_alpha, output ready);
endinterface

interface kcogd_rsp_if;
   logic                 valid;
   logic                 ready;
   kcogd_pkg::chan_type  red;
   kcogd_pkg::chan_type  green;
   kcogd_pkg::chan_type  blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface kcogd_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [kcogd_pkg::CSR_INDEX_W-1:0]     index;
   logic [kcogd_pkg::CSR_DATA_W-1:0]      wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

>>> hw/rtl/kcogd_encode.sv
// Pipelined linear-to-sRGB encoder: two search bits per stage, then a rounding stage.
`include "assert_macros.svh"

module kcogd_encode #(
   parameter int LANES  = 1,
   parameter int SIDE_W = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  kcogd_pkg::lin_type  [LANES-1:0]      in_lin,
   input  logic                [SIDE_W-1:0]     in_side,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output kcogd_pkg::chan_type [LANES-1:0]      out_code,
   output logic                [SIDE_W-1:0]     out_side
);

   localparam int SearchStages = kcogd_pkg::CHAN_W / 2;
   localparam int Stages       = SearchStages + 1;

   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] valid_in;
   logic [Stages-1:0] stage_ready;

   kcogd_pkg::lin_type  lin_ff   [Stages][LANES];
   kcogd_pkg::lin_type  lin_in   [Stages][LANES];
   kcogd_pkg::chan_type code_ff  [Stages][LANES];
   kcogd_pkg::chan_type code_in  [Stages][LANES];
   logic [SIDE_W-1:0]   side_ff  [Stages];
   logic [SIDE_W-1:0]   side_in  [Stages];

   kcogd_pkg::lin_type  src_lin  [Stages][LANES];
   kcogd_pkg::chan_type src_code [Stages][LANES];

   // ready ripples back; an empty stage always takes a beat
   always_comb begin
      stage_ready[Stages-1] = !valid_ff[Stages-1] || out_ready;
      for (int s = Stages - 2; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
   end

   assign valid_in = {valid_ff[Stages-2:0], in_valid};
   assign in_ready = stage_ready[0];

   // stage sources: the input port feeds stage 0
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         src_lin[0][l]  = in_lin[l];
         src_code[0][l] = '0;
      end
      for (int s = 1; s < Stages; s++) begin
         for (int l = 0; l < LANES; l++) begin
            src_lin[s][l]  = lin_ff[s-1][l];
            src_code[s][l] = code_ff[s-1][l];
         end
      end
   end

   // search stages then nearest-code rounding
   always_comb begin
      for (int s = 0; s < Stages; s++) begin
         side_in[s] = (s == 0) ? in_side : side_ff[(s == 0) ? 0 : s - 1];
         for (int l = 0; l < LANES; l++) begin
            lin_in[s][l] = src_lin[s][l];
            if (s < SearchStages) begin
               code_in[s][l] = kcogd_pkg::search_step(src_lin[s][l],
                  kcogd_pkg::search_step(src_lin[s][l], src_code[s][l],
                                         kcogd_pkg::CHAN_W - 1 - 2 * s),
                  kcogd_pkg::CHAN_W - 2 - 2 * s);
            end else begin
               code_in[s][l] = kcogd_pkg::round_code(src_lin[s][l], src_code[s][l]);
            end
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < Stages; s++) begin
            if (stage_ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      for (int s = 0; s < Stages; s++) begin
         if (stage_ready[s]) begin
            side_ff[s] <= side_in[s];
            for (int l = 0; l < LANES; l++) begin
               lin_ff[s][l]  <= lin_in[s][l];
               code_ff[s][l] <= code_in[s][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_code[l] = code_ff[Stages-1][l];
      end
   end

   assign out_valid = valid_ff[Stages-1];
   assign out_side  = side_ff[Stages-1];

   // after the search the code brackets the linear value from below
   `KC_ASSERT_IMPLY(a_search_low, clock, reset, valid_ff[SearchStages-1], kcogd_pkg::LIN_TABLE[code_ff[SearchStages-1][0]] <= lin_ff[SearchStages-1][0])
   // and the next code lies above it
   `KC_ASSERT_IMPLY(a_search_high, clock, reset, valid_ff[SearchStages-1] && code_ff[SearchStages-1][0] != '1, kcogd_pkg::LIN_TABLE[code_ff[SearchStages-1][0] + 8'd1] > lin_ff[SearchStages-1][0])
   // a stalled result holds
   `KC_ASSERT_NEXT(a_out_hold, clock, reset, valid_ff[Stages-1] && !out_ready, valid_ff[Stages-1] && $stable(code_ff[Stages-1][0]))

endmodule

>>> hw/rtl/kcogd_blend.sv
// Overlay blend in the sRGB domain: products, divide by 255, select.
`include "assert_macros.svh"

module kcogd_blend (
   input  logic                                          clock,
   input  logic                                          reset,
   input  kcogd_pkg::cfg_type                            cfg,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  kcogd_pkg::chan_type [kcogd_pkg::RGB_LANES-1:0] in_base,
   input  kcogd_pkg::chan_type [kcogd_pkg::RGB_LANES-1:0] in_over,
   input  kcogd_pkg::chan_type                           in_alpha,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output kcogd_pkg::chan_type [kcogd_pkg::RGB_LANES-1:0] out_chan
);

   localparam int Stages = 3;
   localparam int Lanes  = kcogd_pkg::RGB_LANES;
   localparam int PW     = kcogd_pkg::DIV255_PROD_W;

   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] valid_in;
   logic [Stages-1:0] stage_ready;

   // stage 1: products
   kcogd_pkg::lin_type  [Lanes-1:0] po_ff,    po_in;
   kcogd_pkg::lin_type  [Lanes-1:0] pb_ff,    pb_in;
   kcogd_pkg::chan_type [Lanes-1:0] base1_ff;
   kcogd_pkg::chan_type             alpha1_ff;
   // stage 2: reciprocal product
   logic [Lanes-1:0][PW-1:0]        prod_ff,  prod_in;
   kcogd_pkg::chan_type [Lanes-1:0] base2_ff;
   kcogd_pkg::chan_type             alpha2_ff;
   // stage 3: selected channel
   kcogd_pkg::chan_type [Lanes-1:0] chan3_ff, chan3_in;

   kcogd_pkg::lin_type  [Lanes-1:0] round_sum;
   logic                            use_blend;

   always_comb begin
      stage_ready[Stages-1] = !valid_ff[Stages-1] || out_ready;
      for (int s = Stages - 2; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
   end

   assign valid_in = {valid_ff[Stages-2:0], in_valid};
   assign in_ready = stage_ready[0];

   // over*a and base*(255-a)
   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         po_in[i] = kcogd_pkg::LIN_W'(in_over[i]) * kcogd_pkg::LIN_W'(in_alpha);
         pb_in[i] = kcogd_pkg::LIN_W'(in_base[i])
                  * kcogd_pkg::LIN_W'(kcogd_pkg::chan_type'(~in_alpha));
      end
   end

   // round half up, then divide by 255 via reciprocal
   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         round_sum[i] = po_ff[i] + pb_ff[i] + kcogd_pkg::BLEND_ROUND;
         prod_in[i]   = PW'(round_sum[i]) * PW'(kcogd_pkg::DIV255_RECIP);
      end
   end

   // blend only when overlay or mono mode is enabled and the overlay is not transparent
   assign use_blend = (cfg.mono_mode || cfg.overlay_enable) && (alpha2_ff != '0);

   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         chan3_in[i] = use_blend ? prod_ff[i][kcogd_pkg::DIV255_SHIFT +: kcogd_pkg::CHAN_W]
                                 : base2_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < Stages; s++) begin
            if (stage_ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         po_ff     <= po_in;
         pb_ff     <= pb_in;
         base1_ff  <= in_base;
         alpha1_ff <= in_alpha;
      end
      if (stage_ready[1]) begin
         prod_ff   <= prod_in;
         base2_ff  <= base1_ff;
         alpha2_ff <= alpha1_ff;
      end
      if (stage_ready[2]) begin
         chan3_ff  <= chan3_in;
      end
   end

   assign out_valid = valid_ff[Stages-1];
   assign out_chan  = chan3_ff;

   // a transparent overlay gives back the key color through the divider
   `KC_ASSERT_IMPLY(a_zero_alpha, clock, reset, valid_ff[1] && alpha2_ff == '0,
                    prod_ff[0][kcogd_pkg::DIV255_SHIFT +: kcogd_pkg::CHAN_W] == base2_ff[0])
   // a stalled result holds
   `KC_ASSERT_NEXT(a_blend_hold, clock, reset, valid_ff[Stages-1] && !out_ready,
                   valid_ff[Stages-1] && $stable(chan3_ff))

endmodule

>>> hw/rtl/kcogd_gray.sv
// Grayscale pass: linear average of the three channels, encoded back to sRGB; used only in mono mode.
module kcogd_gray (
   input  logic                                          clock,
   input  logic                                          reset,
   input  kcogd_pkg::cfg_type                            cfg,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  kcogd_pkg::chan_type [kcogd_pkg::RGB_LANES-1:0] in_chan,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output kcogd_pkg::chan_type [kcogd_pkg::RGB_LANES-1:0] out_chan
);

   localparam int Stages = 2;
   localparam int Lanes  = kcogd_pkg::RGB_LANES;
   localparam int SideW  = Lanes * kcogd_pkg::CHAN_W;

   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] valid_in;
   logic [Stages-1:0] stage_ready;

   logic [kcogd_pkg::SUM_W-1:0]     sum_ff,   sum_in;
   kcogd_pkg::chan_type [Lanes-1:0] chan1_ff;
   kcogd_pkg::lin_type              mean_ff,  mean_in;
   kcogd_pkg::chan_type [Lanes-1:0] chan2_ff;

   logic                            enc_ready;
   kcogd_pkg::chan_type [0:0]       gray_code;
   logic [SideW-1:0]                side_out;

   always_comb begin
      stage_ready[Stages-1] = !valid_ff[Stages-1] || enc_ready;
      for (int s = Stages - 2; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
   end

   assign valid_in = {valid_ff[Stages-2:0], in_valid};
   assign in_ready = stage_ready[0];

   // sum of linear values plus one for rounding
   always_comb begin
      sum_in = kcogd_pkg::SUM_W'(1);
      for (int i = 0; i < Lanes; i++) begin
         sum_in = sum_in + kcogd_pkg::SUM_W'(kcogd_pkg::LIN_TABLE[in_chan[i]]);
      end
   end

   assign mean_in = kcogd_pkg::div3(sum_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < Stages; s++) begin
            if (stage_ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         sum_ff   <= sum_in;
         chan1_ff <= in_chan;
      end
      if (stage_ready[1]) begin
         mean_ff  <= mean_in;
         chan2_ff <= chan1_ff;
      end
   end

   // back to sRGB; the unblended channels ride along
   kcogd_encode #(
      .LANES  (1),
      .SIDE_W (SideW)
   ) u_enc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff[Stages-1]),
      .in_ready  (enc_ready),
      .in_lin    (mean_ff),
      .in_side   (chan2_ff),
      .out_valid (out_valid),
      .out_ready (out_ready),
      .out_code  (gray_code),
      .out_side  (side_out)
   );

   assign out_chan = cfg.mono_mode ? {Lanes{gray_code[0]}} : side_out;

endmodule

>>> hw/rtl/kcogd_dim.sv
// Dimming pass: per-channel linear scale by (3-level)/3, encoded back to sRGB.
module kcogd_dim (
   input  logic                                          clock,
   input  logic                                          reset,
   input  kcogd_pkg::cfg_type                            cfg,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  kcogd_pkg::chan_type [kcogd_pkg::RGB_LANES-1:0] in_chan,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output kcogd_pkg::chan_type [kcogd_pkg::RGB_LANES-1:0] out_code,
   output kcogd_pkg::chan_type [kcogd_pkg::RGB_LANES-1:0] out_chan
);

   localparam int Stages = 2;
   localparam int Lanes  = kcogd_pkg::RGB_LANES;
   localparam int SideW  = Lanes * kcogd_pkg::CHAN_W;
   localparam int SW     = kcogd_pkg::SUM_W;

   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] valid_in;
   logic [Stages-1:0] stage_ready;

   logic [Lanes-1:0][SW-1:0]        scaled_ff, scaled_in;
   kcogd_pkg::chan_type [Lanes-1:0] chan1_ff;
   kcogd_pkg::lin_type  [Lanes-1:0] lin_ff,    lin_in;
   kcogd_pkg::chan_type [Lanes-1:0] chan2_ff;

   logic                            enc_ready;
   logic [1:0]                      factor;
   kcogd_pkg::lin_type  [Lanes-1:0] lin_raw;

   always_comb begin
      stage_ready[Stages-1] = !valid_ff[Stages-1] || enc_ready;
      for (int s = Stages - 2; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
   end

   assign valid_in = {valid_ff[Stages-2:0], in_valid};
   assign in_ready = stage_ready[0];

   // L * (3 - level) + 1 by shift and add
   assign factor = kcogd_pkg::DIM_OFF - cfg.dim_level;

   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         lin_raw[i]   = kcogd_pkg::LIN_TABLE[in_chan[i]];
         scaled_in[i] = (factor[1] ? {1'b0, lin_raw[i], 1'b0} : SW'(0))
                      + (factor[0] ? SW'(lin_raw[i]) : SW'(0))
                      + SW'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         lin_in[i] = kcogd_pkg::div3(scaled_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < Stages; s++) begin
            if (stage_ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         scaled_ff <= scaled_in;
         chan1_ff  <= in_chan;
      end
      if (stage_ready[1]) begin
         lin_ff    <= lin_in;
         chan2_ff  <= chan1_ff;
      end
   end

   // three encoder lanes; the undimmed channels ride along
   kcogd_encode #(
      .LANES  (Lanes),
      .SIDE_W (SideW)
   ) u_enc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff[Stages-1]),
      .in_ready  (enc_ready),
      .in_lin    (lin_ff),
      .in_side   (chan2_ff),
      .out_valid (out_valid),
      .out_ready (out_ready),
      .out_code  (out_code),
      .out_side  (out_chan)
   );

endmodule

>>> hw/rtl/key_color_overlay_gray_dim_core.sv
// Top level of the key color overlay, grayscale and dimming pipeline.
//
//   Channel   Dir   Beat
//   req_bus   in    key color (base_*) and overlay color with alpha (over_*)
//   rsp_bus   out   final drive color (red, green, blue)
//   csr_bus   in    register write: index 0 dim_level, 1 mono_mode, 2 overlay_enable
//
// One beat per clock in and out while the response is not stalled; beats pass blend, gray, dim and output register.
// The inverse sRGB search sets the depth: two code bits per stage, then a rounding stage.
// Synchronous reset clears the valid bits and the configuration, not the data registers; no clearing pass.
// Each stage takes a beat when empty or when the next one moves, so bubbles collapse
// and a stalled response does not block the input until the pipeline is full.
// Register writes are taken every cycle; write them only while the pipeline is empty.
module key_color_overlay_gray_dim_core (
   input  logic        clock,
   input  logic        reset,
   kcogd_req_if.sink   req_bus,
   kcogd_rsp_if.source rsp_bus,
   kcogd_csr_if.sink   csr_bus
);

   localparam int Lanes = kcogd_pkg::RGB_LANES;

   kcogd_pkg::cfg_type cfg_ff, cfg_in;

   logic                            blend_valid, blend_ready;
   kcogd_pkg::chan_type [Lanes-1:0] blend_chan;
   logic                            gray_valid, gray_ready;
   kcogd_pkg::chan_type [Lanes-1:0] gray_chan;
   logic                            dim_valid, dim_ready;
   kcogd_pkg::chan_type [Lanes-1:0] dim_code;
   kcogd_pkg::chan_type [Lanes-1:0] dim_chan;

   logic                            rsp_valid_ff;
   kcogd_pkg::chan_type [Lanes-1:0] rgb_ff, rgb_in;

   // register writes
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            kcogd_pkg::CSR_DIM_LEVEL:      cfg_in.dim_level      = csr_bus.wdata[1:0];
            kcogd_pkg::CSR_MONO_MODE:      cfg_in.mono_mode      = csr_bus.wdata[0];
            kcogd_pkg::CSR_OVERLAY_ENABLE: cfg_in.overlay_enable = csr_bus.wdata[0];
            default:                       cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kcogd_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_base   ({req_bus.base_blue, req_bus.base_green, req_bus.base_red}),
      .in_over   ({req_bus.over_blue, req_bus.over_green, req_bus.over_red}),
      .in_alpha  (req_bus.over_alpha),
      .out_valid (blend_valid),
      .out_ready (blend_ready),
      .out_chan  (blend_chan)
   );

   kcogd_gray u_gray (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (blend_valid),
      .in_ready  (blend_ready),
      .in_chan   (blend_chan),
      .out_valid (gray_valid),
      .out_ready (gray_ready),
      .out_chan  (gray_chan)
   );

   kcogd_dim u_dim (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (gray_valid),
      .in_ready  (gray_ready),
      .in_chan   (gray_chan),
      .out_valid (dim_valid),
      .out_ready (dim_ready),
      .out_code  (dim_code),
      .out_chan  (dim_chan)
   );

   // output register: off, dimmed or passed through
   assign dim_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      if (cfg_ff.dim_level == kcogd_pkg::DIM_OFF) begin
         rgb_in = '0;
      end else if (cfg_ff.dim_level != kcogd_pkg::DIM_FULL || cfg_ff.mono_mode) begin
         rgb_in = dim_code;
      end else begin
         rgb_in = dim_chan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dim_ready) begin
         rsp_valid_ff <= dim_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dim_ready) begin
         rgb_ff <= rgb_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.red   = rgb_ff[0];
   assign rsp_bus.green = rgb_ff[1];
   assign rsp_bus.blue  = rgb_ff[2];

endmodule
